// ----- hw/rtl/pstt_pkg.sv -----
package pstt_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CHAN_W  = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 5;

  localparam int unsigned CHANNELS_DEFAULT = 4;
  localparam int unsigned SLOTS_DEFAULT    = 16;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = FUNC_W;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAN_W-1:0] channel;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] time_value;
  } pstt_cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0]  read_time;
    logic               read_valid;
    logic [COUNT_W-1:0] entry_count;
    logic               insert_dropped;
  } pstt_result_t;

endpackage

// ----- hw/rtl/pstt_engine.sv -----
module pstt_engine #(
  parameter int unsigned CHANNELS = pstt_pkg::CHANNELS_DEFAULT,
  parameter int unsigned SLOTS    = pstt_pkg::SLOTS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  pstt_pkg::pstt_cmd_t    cmd_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output pstt_pkg::pstt_result_t res_o
);
  import pstt_pkg::*;

  localparam int unsigned DEPTH = CHANNELS * SLOTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_INS, S_RD, S_PUSH} state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q [CHANNELS];
  logic [CNT_W-1:0]   k_q;
  logic [AW-1:0]      base_q;
  logic [TIME_W-1:0]  tv_q;
  logic [CH_W-1:0]    ch_q;
  pstt_result_t       res_q;

  logic [TIME_W-1:0]  mem_q [DEPTH];
  logic [TIME_W-1:0]  rdata_q;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [TIME_W-1:0]  mem_wdata;

  logic [CH_W+CHAN_W-1:0]  ch_ext;
  logic [CH_W-1:0]         ch_in;
  logic                    chan_ok;
  logic [CNT_W-1:0]        cur_cnt;
  logic [AW-1:0]           base_in;
  logic                    slot_hit, full, accept, shift;
  logic [CNT_W-1:0]        cnt_m1, k_m2, cnt_inc;

  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] w;
    w = {{COUNT_W{1'b0}}, c};
    return w[COUNT_W-1:0];
  endfunction

  always_comb begin
    ch_ext   = {{CH_W{1'b0}}, cmd_i.channel};
    ch_in    = ch_ext[CH_W-1:0];
    chan_ok  = {3'b000, cmd_i.channel} < 5'(CHANNELS);
    cur_cnt  = chan_ok ? cnt_q[ch_in] : '0;
    base_in  = AW'(AW'(ch_in) * AW'(SLOTS));
    slot_hit = {{CNT_W{1'b0}}, cmd_i.slot} < {{SLOT_W{1'b0}}, cur_cnt};
    full     = cur_cnt == CNT_W'(SLOTS);
    accept   = cmd_valid_i && (state_q == S_IDLE);
    cnt_m1   = CNT_W'(cur_cnt - CNT_W'(1));
    k_m2     = CNT_W'(k_q - CNT_W'(2));
    cnt_inc  = CNT_W'(cnt_q[ch_q] + CNT_W'(1));
    shift    = (k_q != '0) && (rdata_q > tv_q);
  end

  // entry k takes either its left neighbor (shift up) or the new time
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (accept && chan_ok) begin
          if (cmd_i.func == FUNC_INSERT && !full && cur_cnt != '0) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(base_in + AW'(cnt_m1));
          end else if (cmd_i.func == FUNC_READ && slot_hit) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(base_in + AW'(cmd_i.slot));
          end
        end
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(base_q + AW'(k_q));
        mem_wdata = shift ? rdata_q : tv_q;
        mem_re    = shift && (k_q > CNT_W'(1));
        mem_raddr = AW'(base_q + AW'(k_m2));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '{default: '0};
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            ch_q   <= ch_in;
            base_q <= base_in;
            tv_q   <= cmd_i.time_value;
            k_q    <= cur_cnt;
            if (!chan_ok) begin
              res_q   <= '0;
              state_q <= S_PUSH;
            end else if (cmd_i.func == FUNC_INSERT) begin
              if (full) begin
                res_q   <= '{read_time: '0, read_valid: 1'b0,
                             entry_count: to_count(cur_cnt), insert_dropped: 1'b1};
                state_q <= S_PUSH;
              end else begin
                res_q   <= '0;
                state_q <= S_INS;
              end
            end else if (cmd_i.func == FUNC_READ) begin
              res_q   <= '{read_time: '0, read_valid: 1'b0,
                           entry_count: to_count(cur_cnt), insert_dropped: 1'b0};
              state_q <= slot_hit ? S_RD : S_PUSH;
            end else if (cmd_i.func == FUNC_CLEAR) begin
              res_q        <= '0;
              cnt_q[ch_in] <= '0;
              state_q      <= S_PUSH;
            end else begin
              res_q   <= '{read_time: '0, read_valid: 1'b0,
                           entry_count: to_count(cur_cnt), insert_dropped: 1'b0};
              state_q <= S_PUSH;
            end
          end
        end
        S_INS: begin
          if (shift) begin
            k_q <= CNT_W'(k_q - CNT_W'(1));
          end else begin
            cnt_q[ch_q]       <= cnt_inc;
            res_q.entry_count <= to_count(cnt_inc);
            state_q           <= S_PUSH;
          end
        end
        S_RD: begin
          res_q   <= '{read_time: rdata_q, read_valid: 1'b1,
                       entry_count: res_q.entry_count, insert_dropped: 1'b0};
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_PUSH);
  assign res_o       = res_q;

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |-> (k_q < CNT_W'(SLOTS)))
    else $error("insert walk index beyond list");

  a_read_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> $past(mem_re))
    else $error("read data used without a memory read");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS && !shift) |=>
      (cnt_q[ch_q] == CNT_W'($past(cnt_q[ch_q]) + CNT_W'(1))))
    else $error("insert did not bump the count by one");

endmodule

// ----- hw/rtl/per_channel_sorted_time_table.sv -----
// Flow: an insert walks the list in S_INS, moving m entries up (m = 0..SLOTS-1), then writes
//   the new time; a read passes S_RD; all results then pass S_PUSH and the output register.
// Throughput: one item at a time; an insert walks the list one entry per cycle through the
//   store's write and read ports.
// Reset: all list counts zero, no result pending; the time store holds no reset value.
module per_channel_sorted_time_table #(
  parameter int unsigned CHANNELS = pstt_pkg::CHANNELS_DEFAULT,
  parameter int unsigned SLOTS    = pstt_pkg::SLOTS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // channel[1:0], slot[5:2], time_value[37:6], zero[39:38]
  input  logic [pstt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func[1:0]
  input  logic [pstt_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // read_time[31:0], entry_count[36:32], zero[39:37]
  output logic [pstt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // read_valid[0], insert_dropped[1]
  output logic [pstt_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import pstt_pkg::*;

  pstt_cmd_t    cmd;
  pstt_result_t res, out_q;
  logic         res_valid, res_ready, out_valid_q;

  always_comb begin
    cmd.func       = s_axis_tuser[FUNC_W-1:0];
    cmd.channel    = s_axis_tdata[1:0];
    cmd.slot       = s_axis_tdata[5:2];
    cmd.time_value = s_axis_tdata[37:6];
  end

  pstt_engine #(
    .CHANNELS (CHANNELS),
    .SLOTS    (SLOTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.entry_count, out_q.read_time};
  assign m_axis_tuser  = {out_q.insert_dropped, out_q.read_valid};

endmodule
